### hdl/eqc_pkg.sv
// Shared constants, types and fixed-point helpers for the circuit equaliser.
`default_nettype none
package eqc_pkg;
   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 32;
   localparam int STATE_W    = 32;
   localparam int STATE_FRAC = 24;
   localparam int CF         = COEF_W - 4;
   localparam int SF         = SAMPLE_W - 1;
   localparam int SH_IN      = SF + CF - STATE_FRAC;
   localparam int SH_COEF    = CF;
   localparam int SH_OUT     = STATE_FRAC + CF - SF;
   localparam int MUL_W      = COEF_W + 1;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = 42;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int NUM_BANDS_DEF = 5;

   localparam logic [COEF_W-1:0] GAIN_ONE = COEF_W'(64'd1 << CF);

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_COEF   = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_kind_type;

   localparam logic [1:0] SEL_WIPER    = 2'd0;
   localparam logic [1:0] SEL_COND     = 2'd1;
   localparam logic [1:0] SEL_FEEDBACK = 2'd2;
   localparam logic [1:0] SEL_CAPGAIN  = 2'd3;

   localparam logic REG_DIRECT = 1'b0;
   localparam logic REG_NODE   = 1'b1;

   typedef struct packed {
      logic signed [STATE_W-1:0] s;
      logic signed [STATE_W-1:0] vc;
      logic signed [STATE_W-1:0] v;
      logic signed [STATE_W-1:0] i;
   } state_row_type;

   // round to nearest, ties away from zero
   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PROD_W-1:0] p,
                                                    input int sh);
      logic signed [PROD_W-1:0] biased;
      biased = p + (PROD_W'(1) <<< (sh - 1)) - PROD_W'(p[PROD_W-1]);
      return ACC_W'(biased >>> sh);
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
      lo = -hi - ACC_W'(1);
      if (x > hi) return STATE_W'(hi);
      else if (x < lo) return STATE_W'(lo);
      else return STATE_W'(x);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
      lo = -hi - ACC_W'(1);
      if (x > hi) return SAMPLE_W'(hi);
      else if (x < lo) return SAMPLE_W'(lo);
      else return SAMPLE_W'(x);
   endfunction
endpackage
`default_nettype wire

### hdl/eqc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module eqc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

### hdl/five_band_circuit_eq_sample_step.sv
// Top level of the circuit graphic equaliser: sequencer, shared multiplier and state RAMs.
// One signed 33x33 multiplier is shared by all multiplications; band coefficients and the band
// state (current, wiper voltage, capacitor voltage, state term) sit in two registered-read RAMs.
// For a sample item the sequencer steps the shared multiplier through every band twice, and
// it holds at the node step while an earlier result still waits in the output register.
// The result is loaded into that register before the band update pass, so the next item
// can be taken while it waits. A coefficient write goes to the RAM as its beat is accepted;
// a clear item zeroes the band state rows. After reset a clearing pass zeroes both RAMs
// before the first item is accepted; CSR writes are taken at any time.
`default_nettype none
module five_band_circuit_eq_sample_step #(
   parameter int NUM_BANDS = eqc_pkg::NUM_BANDS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // sample_in[23:0], band_index[27:24], coef_select[29:28], coef_value[61:30], zero[63:62]
   input  wire logic [eqc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type[1:0]
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // sample_out[23:0]
   output logic [eqc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [eqc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import eqc_pkg::*;

   localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int CDEPTH = 4 * NUM_BANDS;
   localparam int CAW    = $clog2(CDEPTH);
   localparam int ROW_W  = $bits(state_row_type);
   localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);
   localparam logic [CAW-1:0]    SWEEP_ALL = CAW'(CDEPTH - 1);
   localparam logic [CAW-1:0]    SWEEP_ROW = CAW'(NUM_BANDS - 1);
   localparam logic [CAW-1:0]    NB_C      = CAW'(NUM_BANDS);
   localparam logic [4:0]        NB_IDX    = 5'(NUM_BANDS);

   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_ACC0, ST_ACC1,
      ST_P1_A, ST_P1_B, ST_P1_C, ST_P1_D, ST_P1_E,
      ST_N_A, ST_N_B,
      ST_P2_A, ST_P2_B, ST_P2_C, ST_P2_D, ST_P2_E, ST_P2_F, ST_P2_G, ST_P2_H
   } state_type;

   state_type state_ff;
   logic [CAW-1:0]    sweep_ff;
   logic              clr_coef_ff;
   logic [BAND_W-1:0] band_ff;
   logic signed [COEF_W-1:0]   dpg_ff, nig_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [ACC_W-1:0]    acc_ff, t_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [COEF_W-1:0]   g_ff, k_ff, gc_ff;
   logic signed [STATE_W-1:0]  i_ff, v_ff, vc_ff, s_ff, vout_ff, vnew_ff, cur_ff;
   logic              rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_data_ff;

   // request fields
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [3:0]                 band_index;
   logic [1:0]                 coef_select;
   logic [COEF_W-1:0]          coef_value;
   assign sample_in   = req_tdata[23:0];
   assign band_index  = req_tdata[27:24];
   assign coef_select = req_tdata[29:28];
   assign coef_value  = req_tdata[61:30];

   logic req_accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // CSR port
   logic csr_write;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_NODE) ? nig_ff : dpg_ff;

   // RAM ports
   logic              coef_we;
   logic [CAW-1:0]    coef_waddr, coef_raddr;
   logic [COEF_W-1:0] coef_wdata_in, coef_rd;
   logic              row_we;
   logic [BAND_W-1:0] row_waddr, row_raddr;
   state_row_type     row_wdata_in, row_rd;
   logic [BAND_W-1:0] rd_band;
   logic [1:0]        rd_sel;
   logic [BAND_W+1:0] rd_cat;
   logic [5:0]        wr_cat;
   logic [BAND_W-1:0] band_next;

   eqc_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_coef_ram (
      .clock(clock), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata_in),
      .raddr(coef_raddr), .rdata(coef_rd)
   );

   eqc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BANDS)) u_state_ram (
      .clock(clock), .we(row_we), .waddr(row_waddr), .wdata(row_wdata_in),
      .raddr(row_raddr), .rdata(row_rd)
   );

   // shared multiplier operands
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic                     mul_en;
   logic signed [COEF_W-1:0] coef_rd_s;
   logic signed [ACC_W-1:0]  r28, r27, r29;
   logic signed [STATE_W-1:0] node, s_new, vc_new, acc_sat;
   logic                     rsp_free;

   assign coef_rd_s = coef_rd;
   assign r27 = rnd(prod_ff, SH_IN);
   assign r28 = rnd(prod_ff, SH_COEF);
   assign r29 = rnd(prod_ff, SH_OUT);
   assign acc_sat  = sat_state(acc_ff);
   assign node     = sat_state(r28);
   assign s_new    = sat_state(t_ff - (r28 <<< 1));
   assign vc_new   = sat_state(ACC_W'(vc_ff) + t_ff + r28);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign band_next = (band_ff == LAST_BAND) ? '0 : band_ff + BAND_W'(1);

   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         ST_ACC0: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'(dpg_ff);
         end
         ST_P1_B: begin
            mul_a = MUL_W'(coef_rd_s);
            mul_b = MUL_W'(i_ff);
         end
         ST_P1_C: begin
            mul_a = MUL_W'(g_ff);
            mul_b = MUL_W'(v_ff);
         end
         ST_P1_D: begin
            mul_a = MUL_W'(g_ff);
            mul_b = MUL_W'(vc_ff);
         end
         ST_N_A: begin
            mul_a = MUL_W'(acc_sat);
            mul_b = MUL_W'(nig_ff);
         end
         ST_P2_A: begin
            mul_a = MUL_W'(signed'(GAIN_ONE)) - MUL_W'(coef_rd_s);
            mul_b = MUL_W'(x_ff);
         end
         ST_P2_B: begin
            mul_a = MUL_W'(k_ff);
            mul_b = MUL_W'(vout_ff);
         end
         ST_P2_D: begin
            mul_a = MUL_W'(g_ff);
            mul_b = MUL_W'(vnew_ff);
         end
         ST_P2_F: begin
            mul_a = MUL_W'(gc_ff);
            mul_b = MUL_W'(cur_ff);
         end
         ST_P2_G: begin
            mul_a = MUL_W'(gc_ff);
            mul_b = MUL_W'(i_ff);
         end
         default: mul_en = 1'b0;
      endcase
   end

   // RAM addressing and writes
   always_comb begin
      rd_band = band_ff;
      rd_sel  = SEL_WIPER;
      unique case (state_ff)
         ST_ACC1: begin
            rd_band = '0;
            rd_sel  = SEL_COND;
         end
         ST_P1_A: rd_sel = SEL_FEEDBACK;
         ST_P1_E: begin
            rd_band = band_next;
            rd_sel  = SEL_COND;
         end
         ST_N_B:  rd_band = '0;
         ST_P2_A: rd_sel = SEL_COND;
         ST_P2_B: rd_sel = SEL_CAPGAIN;
         ST_P2_H: rd_band = band_next;
         default: rd_sel = SEL_WIPER;
      endcase
      rd_cat     = {rd_band, rd_sel};
      coef_raddr = rd_cat[CAW-1:0];
      row_raddr  = rd_band;

      wr_cat = {band_index, coef_select};
      if (state_ff == ST_CLR) begin
         coef_we       = clr_coef_ff;
         coef_waddr    = sweep_ff;
         coef_wdata_in = '0;
      end else begin
         coef_we       = req_accept && (req_tuser == REQ_COEF) && ({1'b0, band_index} < NB_IDX);
         coef_waddr    = wr_cat[CAW-1:0];
         coef_wdata_in = coef_value;
      end

      row_we       = 1'b0;
      row_waddr    = band_ff;
      row_wdata_in = '0;
      unique case (state_ff)
         ST_CLR: begin
            row_we    = (sweep_ff < NB_C);
            row_waddr = sweep_ff[BAND_W-1:0];
         end
         ST_P1_E: begin
            row_we       = 1'b1;
            row_wdata_in = '{s: s_new, vc: vc_ff, v: v_ff, i: i_ff};
         end
         ST_P2_H: begin
            row_we       = 1'b1;
            row_wdata_in = '{s: s_ff, vc: vc_new, v: vnew_ff, i: cur_ff};
         end
         default: row_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (reset) begin
         state_ff     <= ST_CLR;
         sweep_ff     <= '0;
         clr_coef_ff  <= 1'b1;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         dpg_ff       <= GAIN_ONE;
         nig_ff       <= GAIN_ONE;
      end else begin
         if (csr_write) begin
            if (csr_paddr[2] == REG_NODE) nig_ff <= csr_pwdata;
            else dpg_ff <= csr_pwdata;
         end
         // the node step reloads the register itself when the waiting beat leaves
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_N_B)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLR: begin
               sweep_ff <= sweep_ff + CAW'(1);
               if (sweep_ff == (clr_coef_ff ? SWEEP_ALL : SWEEP_ROW)) begin
                  clr_coef_ff <= 1'b0;
                  state_ff    <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  x_ff <= sample_in;
                  unique case (req_tuser)
                     REQ_SAMPLE: state_ff <= ST_ACC0;
                     REQ_CLEAR: begin
                        sweep_ff <= '0;
                        state_ff <= ST_CLR;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_ACC0: state_ff <= ST_ACC1;
            ST_ACC1: begin
               acc_ff   <= r27;
               band_ff  <= '0;
               state_ff <= ST_P1_A;
            end
            ST_P1_A: begin
               g_ff     <= coef_rd;
               i_ff     <= row_rd.i;
               v_ff     <= row_rd.v;
               vc_ff    <= row_rd.vc;
               state_ff <= ST_P1_B;
            end
            ST_P1_B: state_ff <= ST_P1_C;
            ST_P1_C: begin
               t_ff     <= r28;
               state_ff <= ST_P1_D;
            end
            ST_P1_D: begin
               t_ff     <= t_ff + r28;
               state_ff <= ST_P1_E;
            end
            ST_P1_E: begin
               acc_ff  <= acc_ff + ACC_W'(s_new);
               band_ff <= band_next;
               state_ff <= (band_ff == LAST_BAND) ? ST_N_A : ST_P1_A;
            end
            ST_N_A: state_ff <= ST_N_B;
            ST_N_B: begin
               // hold until the output register is free
               if (rsp_free) begin
                  vout_ff      <= sat_state(-ACC_W'(node));
                  rsp_data_ff  <= sat_sample(r29);
                  rsp_valid_ff <= 1'b1;
                  band_ff      <= '0;
                  state_ff     <= ST_P2_A;
               end
            end
            ST_P2_A: begin
               k_ff     <= coef_rd;
               i_ff     <= row_rd.i;
               vc_ff    <= row_rd.vc;
               s_ff     <= row_rd.s;
               state_ff <= ST_P2_B;
            end
            ST_P2_B: begin
               t_ff     <= r27;
               g_ff     <= coef_rd;
               state_ff <= ST_P2_C;
            end
            ST_P2_C: begin
               vnew_ff  <= sat_state(t_ff + r28);
               gc_ff    <= coef_rd;
               state_ff <= ST_P2_D;
            end
            ST_P2_D: state_ff <= ST_P2_E;
            ST_P2_E: begin
               cur_ff   <= sat_state(r28 + ACC_W'(s_ff));
               state_ff <= ST_P2_F;
            end
            ST_P2_F: state_ff <= ST_P2_G;
            ST_P2_G: begin
               t_ff     <= r28;
               state_ff <= ST_P2_H;
            end
            ST_P2_H: begin
               band_ff  <= band_next;
               state_ff <= (band_ff == LAST_BAND) ? ST_IDLE : ST_P2_A;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_from_node: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_N_B)
      else $error("result loaded outside node solve");
   a_row_write_src: assert property (@(posedge clock) disable iff (reset)
      row_we |-> (state_ff == ST_CLR || state_ff == ST_P1_E || state_ff == ST_P2_H))
      else $error("state row written outside update");
   a_band_range: assert property (@(posedge clock) disable iff (reset)
      band_ff <= LAST_BAND)
      else $error("band counter out of range");
   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == REQ_SAMPLE) |=> state_ff == ST_ACC0)
      else $error("sample beat did not start the sequence");
endmodule
`default_nettype wire

### tb/five_band_circuit_eq_sample_step_tb.sv
// Self-checking testbench for the five-band circuit equaliser sample step.
`timescale 1ns / 1ps
module five_band_circuit_eq_sample_step_tb;
   import eqc_pkg::*;

   localparam int NBANDS = 5;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_DIRECT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_NODE   = 3'd4;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic [1:0]          kind;
      logic [SAMPLE_W-1:0] smp;
      logic [3:0]          band;
      logic [1:0]          sel;
      logic [COEF_W-1:0]   coef;
      bit                  typed;
      logic [SAMPLE_W-1:0] want;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   five_band_circuit_eq_sample_step uut (.*);

   always #5 clock = ~clock;

   // equaliser model state
   longint gain_direct, gain_node;
   longint coefs [NBANDS*4];
   longint br_cur [NBANDS];
   longint wip_v [NBANDS];
   longint cap_v [NBANDS];

   logic [SAMPLE_W-1:0] pending_out [$];
   int fail_count = 0;
   int samples_out = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic longint clamp_to(longint x, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
   endfunction

   // product rounded half away from zero, magnitude clamped at 2^56
   function automatic longint scaled_mul(longint a, longint b, int sh);
      logic signed [127:0] pa;
      logic signed [127:0] pb;
      logic signed [127:0] p;
      logic [127:0] m;
      logic [127:0] q;
      pa = a;
      pb = b;
      p = pa * pb;
      m = p < 0 ? -p : p;
      q = (m + (128'd1 << (sh - 1))) >> sh;
      if (q > (128'd1 << 56)) q = 128'd1 << 56;
      return p < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic void model_reset();
      gain_direct = longint'(1) <<< CF;
      gain_node = longint'(1) <<< CF;
      foreach (coefs[i]) coefs[i] = 0;
      foreach (br_cur[i]) begin
         br_cur[i] = 0;
         wip_v[i] = 0;
         cap_v[i] = 0;
      end
   endfunction

   // advance the model by one beat; returns 1 with the output when a sample is produced
   function automatic bit equalise(logic [1:0] kind, logic [SAMPLE_W-1:0] smp,
                                   logic [3:0] band, logic [1:0] sel,
                                   logic [COEF_W-1:0] coef, output logic [SAMPLE_W-1:0] y);
      longint s [NBANDS];
      longint x, acc, node, vneg, outv, k, g, a1, gc, v, cur;
      y = '0;
      if (kind == REQ_COEF) begin
         if (band < NBANDS) coefs[band*4 + sel] = longint'(signed'(coef));
         return 0;
      end
      if (kind == REQ_CLEAR) begin
         foreach (br_cur[i]) begin
            br_cur[i] = 0;
            wip_v[i] = 0;
            cap_v[i] = 0;
         end
         return 0;
      end
      if (kind != REQ_SAMPLE) return 0;
      x = longint'(signed'(smp));
      acc = scaled_mul(x, gain_direct, SH_IN);
      for (int i = 0; i < NBANDS; i++) begin
         g = coefs[i*4 + SEL_COND];
         a1 = coefs[i*4 + SEL_FEEDBACK];
         s[i] = clamp_to(scaled_mul(a1, br_cur[i], CF) + scaled_mul(g, wip_v[i], CF)
                         - 2 * scaled_mul(g, cap_v[i], CF), STATE_W);
         acc += s[i];
      end
      acc = clamp_to(acc, STATE_W);
      node = clamp_to(scaled_mul(acc, gain_node, CF), STATE_W);
      outv = clamp_to(scaled_mul(acc, gain_node, SH_OUT), SAMPLE_W);
      vneg = clamp_to(-node, STATE_W);
      for (int i = 0; i < NBANDS; i++) begin
         k = coefs[i*4 + SEL_WIPER];
         g = coefs[i*4 + SEL_COND];
         gc = coefs[i*4 + SEL_CAPGAIN];
         v = clamp_to(scaled_mul((longint'(1) <<< CF) - k, x, SH_IN)
                      + scaled_mul(k, vneg, CF), STATE_W);
         cur = clamp_to(scaled_mul(g, v, CF) + s[i], STATE_W);
         cap_v[i] = clamp_to(cap_v[i] + scaled_mul(gc, cur, CF)
                             + scaled_mul(gc, br_cur[i], CF), STATE_W);
         br_cur[i] = cur;
         wip_v[i] = v;
      end
      y = outv[SAMPLE_W-1:0];
      return 1;
   endfunction

   task automatic push_beat(step_row_type r);
      logic [SAMPLE_W-1:0] y;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {2'b00, r.coef, r.sel, r.band, r.smp};
      do @(posedge clock); while (!req_tready);
      if (equalise(r.kind, r.smp, r.band, r.sel, r.coef, y)) begin
         if (r.typed && y !== r.want) begin
            $error("directed row model disagrees: sample_out expected %0d got %0d",
                   $signed(r.want), $signed(y));
            fail_count++;
         end
         pending_out.push_back(y);
      end
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_DIRECT) gain_direct = longint'(signed'(value));
      else gain_node = longint'(signed'(value));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COEF_W-1:0] rand_coef();
      // mostly within plus or minus unity, sometimes full range
      if ($urandom_range(3) == 0) return $urandom;
      return COEF_W'($signed($urandom_range(2**29)) - 2**28);
   endfunction

   function automatic step_row_type rand_row();
      step_row_type r;
      int pick;
      pick = $urandom_range(99);
      r.kind = pick < 70 ? REQ_SAMPLE : pick < 90 ? REQ_COEF : pick < 95 ? REQ_CLEAR
               : REQ_UNUSED;
      r.smp = SAMPLE_W'($urandom);
      if ($urandom_range(1)) r.smp = SAMPLE_W'($signed(r.smp) >>> $urandom_range(12));
      r.band = $urandom_range(3) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(4));
      r.sel = 2'($urandom_range(3));
      r.coef = rand_coef();
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            $error("sample_out beat with nothing outstanding: %0d", $signed(rsp_tdata));
            fail_count++;
         end else begin
            if (rsp_tdata !== pending_out[0]) begin
               $error("sample_out mismatch: expected %0d actual %0d",
                      $signed(pending_out[0]), $signed(rsp_tdata));
               fail_count++;
            end
            void'(pending_out.pop_front());
            samples_out++;
         end
      end
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      step_row_type dir_rows [20];
      int send_mix [5];
      int stall_mix [5];
      logic [31:0] gains [5][2];
      dir_rows = '{
         // unity gains and empty coefficients pass the sample straight through
         '{REQ_SAMPLE, 24'h7fffff, 4'd0, 2'd0, 32'd0, 1'b1, 24'h7fffff},
         '{REQ_SAMPLE, 24'h800000, 4'd0, 2'd0, 32'd0, 1'b1, 24'h800000},
         '{REQ_SAMPLE, 24'h000000, 4'd0, 2'd0, 32'd0, 1'b1, 24'h000000},
         '{REQ_SAMPLE, 24'h000001, 4'd0, 2'd0, 32'd0, 1'b1, 24'h000001},
         '{REQ_SAMPLE, 24'hffffff, 4'd0, 2'd0, 32'd0, 1'b1, 24'hffffff},
         '{REQ_COEF, 24'h0, 4'd0, SEL_WIPER,    32'h0800_0000, 1'b0, 24'h0},
         '{REQ_COEF, 24'h0, 4'd0, SEL_COND,     32'h0400_0000, 1'b0, 24'h0},
         '{REQ_COEF, 24'h0, 4'd0, SEL_FEEDBACK, 32'hf000_0000, 1'b0, 24'h0},
         '{REQ_COEF, 24'h0, 4'd0, SEL_CAPGAIN,  32'h0100_0000, 1'b0, 24'h0},
         '{REQ_COEF, 24'h0, 4'd4, SEL_COND,     32'h7fff_ffff, 1'b0, 24'h0},
         '{REQ_COEF, 24'h0, 4'd4, SEL_FEEDBACK, 32'h8000_0000, 1'b0, 24'h0},
         // out-of-range bands must leave everything alone
         '{REQ_COEF, 24'h0, 4'd5,  SEL_COND, 32'h7fff_ffff, 1'b0, 24'h0},
         '{REQ_COEF, 24'h0, 4'd15, SEL_COND, 32'h8000_0000, 1'b0, 24'h0},
         '{REQ_UNUSED, 24'h7fffff, 4'd15, 2'd3, 32'hffff_ffff, 1'b0, 24'h0},
         '{REQ_SAMPLE, 24'h400000, 4'd0, 2'd0, 32'd0, 1'b0, 24'h0},
         '{REQ_SAMPLE, 24'h7fffff, 4'd0, 2'd0, 32'd0, 1'b0, 24'h0},
         '{REQ_SAMPLE, 24'h800000, 4'd0, 2'd0, 32'd0, 1'b0, 24'h0},
         '{REQ_CLEAR, 24'h0, 4'd0, 2'd0, 32'd0, 1'b0, 24'h0},
         '{REQ_SAMPLE, 24'h123456, 4'd0, 2'd0, 32'd0, 1'b0, 24'h0},
         '{REQ_SAMPLE, 24'hedcba9, 4'd0, 2'd0, 32'd0, 1'b0, 24'h0}
      };
      send_mix = '{0, 55, 0, 13, 0};
      stall_mix = '{0, 0, 55, 13, 0};
      gains = '{'{32'h1000_0000, 32'h1000_0000}, '{32'h7fff_ffff, 32'h0200_0000},
                '{32'h8000_0000, 32'h7fff_ffff}, '{32'h0800_0000, 32'h8000_0000},
                '{32'h1000_0000, 32'h0c00_0000}};
      model_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) push_beat(dir_rows[i]);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = send_mix[ph];
         recv_stall_pct = stall_mix[ph];
         write_reg(ADDR_DIRECT, gains[ph][0]);
         write_reg(ADDR_NODE, ph == 4 ? rand_coef() : gains[ph][1]);
         for (int n = 0; n < 90; n++) push_beat(rand_row());
         drain();
      end

      $display("Covered %0d samples over 5 gain settings, including band writes, clears,",
               samples_out);
      $display("unused request codes and both sender gaps and receiver stalls.");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
